// ===== rtl/ptt_pkg.sv =====
// Shared types and constants for the periodic timer table.
// Used by ptt_slot_eval and periodic_timer_table_core; depends on nothing.
package ptt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TICK_MS    = 10;

    localparam int IDX_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W     = $clog2(NUM_TIMERS + 1);
    localparam int ID_W      = 16;
    localparam int PERIOD_W  = 24;
    localparam int ELAPSED_W = 25;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_UPDATED = 2'd1;
    localparam logic [1:0] STATUS_ADDED   = 2'd2;
    localparam logic [1:0] STATUS_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic [ID_W-1:0]     timer_id;
        logic [ID_W-1:0]     custom_id;
        logic                any_custom;
        logic [PERIOD_W-1:0] period_ms;
        logic                want_signal;
        logic                want_work;
    } cmd_t;

    typedef struct packed {
        logic            fired;
        logic [ID_W-1:0] fired_id;
        logic [ID_W-1:0] fired_custom;
        logic            notify_signal;
        logic            notify_work;
        logic [1:0]      status;
        logic            last;
    } rsp_t;

    // one RAM word per slot; notify bit 0 is signal, bit 1 is work
    typedef struct packed {
        logic [ID_W-1:0]      owner;
        logic [ID_W-1:0]      custom;
        logic [PERIOD_W-1:0]  period;
        logic [ELAPSED_W-1:0] elapsed;
        logic [1:0]           notify;
    } slot_t;

    // per-slot decision handed from the evaluator to the sequencer
    typedef struct packed {
        logic  fire;
        logic  wr_en;
        slot_t wr_data;
        logic  free_slot;
        logic  set_expired;
        logic  add_match;
        logic  add_free;
    } eval_t;

endpackage

// ===== rtl/ptt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Stand-alone; no package needed.
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // data holds while no read is issued
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/ptt_slot_eval.sv =====
// Per-slot evaluation: decides what one item does to one slot.
// Depends on ptt_pkg.
module ptt_slot_eval
    import ptt_pkg::*;
(
    input  cmd_t  cmd,
    input  logic  used,
    input  logic  expired,
    input  slot_t slot,
    output eval_t ev
);

    logic [ELAPSED_W-1:0] elapsed_sum;
    logic                 owner_hit;
    logic                 custom_hit;

    assign elapsed_sum = slot.elapsed + ELAPSED_W'(TICK_MS);
    assign owner_hit   = (slot.owner == cmd.timer_id);
    assign custom_hit  = (slot.custom == cmd.custom_id);

    always_comb
    begin
        ev         = '0;
        ev.wr_data = slot;
        case (cmd.kind)
            KIND_TICK:
            begin
                if (used && expired)
                begin
                    ev.free_slot = 1'b1;
                end
                else if (used)
                begin
                    ev.wr_en = 1'b1;
                    if (elapsed_sum >= {1'b0, slot.period})
                    begin
                        ev.fire               = 1'b1;
                        ev.wr_data.elapsed    = '0;
                    end
                    else
                    begin
                        ev.wr_data.elapsed    = elapsed_sum;
                    end
                end
            end
            KIND_ADD:
            begin
                ev.add_match = used && owner_hit && custom_hit;
                ev.add_free  = !used;
            end
            KIND_REMOVE:
            begin
                ev.set_expired = used && owner_hit && (cmd.any_custom || custom_hit);
            end
            default:
            begin
                ev.wr_en = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/periodic_timer_table_core.sv =====
// Periodic timer table: slot records in one RAM, scanned one slot per cycle unless
// a fire beat is held back by rsp_stall. cmd_stall stays high until the closing beat
// is registered, so a new item is taken only after the last one has finished.
// Reset clears the used and expired flags at once; RAM contents are not cleared.
// Depends on ptt_pkg, ptt_ram, ptt_slot_eval.
module periodic_timer_table_core
    import ptt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [NUM_TIMERS-1:0] used_reg, expired_reg;
    logic [CNT_W-1:0]    rd_cnt_reg;
    logic                p_valid_reg;
    logic [IDX_W-1:0]    p_idx_reg;
    logic                match_found_reg, free_found_reg;
    logic [IDX_W-1:0]    match_idx_reg, free_idx_reg;
    slot_t               match_data_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;

    logic                cmd_accept;
    logic                out_free;
    logic                eval_ok;
    logic                advance;
    logic                rd_en;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    slot_t               wr_data;
    slot_t               rd_data;
    eval_t               ev;
    logic                scan_done;
    logic                fin_go;
    logic                rsp_load;
    rsp_t                rsp_next;
    logic [1:0]          fin_status;

    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    ptt_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (NUM_TIMERS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    ptt_slot_eval u_eval (
        .cmd     (cmd_reg),
        .used    (used_reg[p_idx_reg]),
        .expired (expired_reg[p_idx_reg]),
        .slot    (rd_data),
        .ev      (ev)
    );

    // hold the read pipe when a fire beat cannot be registered
    assign eval_ok   = (state_reg == ST_SCAN) && p_valid_reg && (!ev.fire || out_free);
    assign advance   = (state_reg == ST_SCAN) && (!p_valid_reg || eval_ok);
    assign rd_en     = advance && (rd_cnt_reg < CNT_W'(NUM_TIMERS));
    assign scan_done = (state_reg == ST_SCAN) && !p_valid_reg
                       && (rd_cnt_reg == CNT_W'(NUM_TIMERS));
    assign fin_go    = (state_reg == ST_FIN) && out_free;

    always_comb
    begin
        fin_status = STATUS_DONE;
        if (cmd_reg.kind == KIND_ADD)
        begin
            if (match_found_reg)
            begin
                fin_status = STATUS_UPDATED;
            end
            else if (free_found_reg)
            begin
                fin_status = STATUS_ADDED;
            end
            else
            begin
                fin_status = STATUS_FULL;
            end
        end
    end

    // RAM write: per-slot counter update during the scan, add commit at the end
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = p_idx_reg;
        wr_data = ev.wr_data;
        if (eval_ok && ev.wr_en)
        begin
            wr_en = 1'b1;
        end
        else if (fin_go && (fin_status == STATUS_UPDATED))
        begin
            wr_en          = 1'b1;
            wr_addr        = match_idx_reg;
            wr_data        = match_data_reg;
            wr_data.period = cmd_reg.period_ms;
        end
        else if (fin_go && (fin_status == STATUS_ADDED))
        begin
            wr_en          = 1'b1;
            wr_addr        = free_idx_reg;
            wr_data.owner  = cmd_reg.timer_id;
            wr_data.custom = cmd_reg.custom_id;
            wr_data.period = cmd_reg.period_ms;
            wr_data.elapsed = '0;
            wr_data.notify = {cmd_reg.want_work, cmd_reg.want_signal};
        end
    end

    always_comb
    begin
        rsp_load = 1'b0;
        rsp_next = '0;
        if (eval_ok && ev.fire)
        begin
            rsp_load               = 1'b1;
            rsp_next.fired         = 1'b1;
            rsp_next.fired_id      = rd_data.owner;
            rsp_next.fired_custom  = rd_data.custom;
            rsp_next.notify_signal = rd_data.notify[0];
            rsp_next.notify_work   = rd_data.notify[1];
        end
        else if (fin_go)
        begin
            rsp_load        = 1'b1;
            rsp_next.status = fin_status;
            rsp_next.last   = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    if (cmd.kind inside {KIND_TICK, KIND_ADD, KIND_REMOVE})
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            used_reg        <= '0;
            expired_reg     <= '0;
            rd_cnt_reg      <= '0;
            p_valid_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cmd_accept)
            begin
                rd_cnt_reg      <= '0;
                p_valid_reg     <= 1'b0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            else if (advance)
            begin
                p_valid_reg <= rd_en;
                if (rd_en)
                begin
                    rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                end
            end

            if (eval_ok)
            begin
                if (ev.free_slot)
                begin
                    used_reg[p_idx_reg]    <= 1'b0;
                    expired_reg[p_idx_reg] <= 1'b0;
                end
                if (ev.set_expired)
                begin
                    expired_reg[p_idx_reg] <= 1'b1;
                end
                if (ev.add_match && !match_found_reg)
                begin
                    match_found_reg <= 1'b1;
                end
                if (ev.add_free && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end

            if (fin_go && (fin_status == STATUS_ADDED))
            begin
                used_reg[free_idx_reg]    <= 1'b1;
                expired_reg[free_idx_reg] <= 1'b0;
            end

            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            cmd_reg <= cmd;
        end
        if (rd_en)
        begin
            p_idx_reg <= rd_cnt_reg[IDX_W-1:0];
        end
        if (eval_ok && ev.add_match && !match_found_reg)
        begin
            match_idx_reg  <= p_idx_reg;
            match_data_reg <= rd_data;
        end
        if (eval_ok && ev.add_free && !free_found_reg)
        begin
            free_idx_reg <= p_idx_reg;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> (state_reg == ST_SCAN))
        else $error("read pipe active outside scan");

    a_last_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && rsp_next.last) |-> (state_reg == ST_FIN))
        else $error("closing beat loaded outside finish");

    a_expired_used: assert property (@(posedge clk) disable iff (!rst_n)
        (expired_reg & ~used_reg) == '0)
        else $error("expired flag set on a free slot");

    a_fire_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && ev.fire && !out_free) |=> (p_valid_reg && $stable(p_idx_reg)))
        else $error("stalled fire slot lost");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for periodic_timer_table_core: directed and random commands,
// with an in-bench timer table that predicts every response beat. Depends on ptt_pkg.
module testbench
    import ptt_pkg::*;
();

    localparam logic [1:0] KIND_SPARE   = 2'd3;
    localparam int         ITEM_TARGET  = 380;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         SETTLE_TICKS = 40;
    localparam int         IDLE_PCT     = 21;

    class timer_checker;
        logic        used    [NUM_TIMERS];
        logic        expired [NUM_TIMERS];
        slot_t       rec     [NUM_TIMERS];
        rsp_t        due_responses[$];
        int          errors;
        int          reported;

        function new();
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                used[i]    = 1'b0;
                expired[i] = 1'b0;
                rec[i]     = '0;
            end
            errors   = 0;
            reported = 0;
        endfunction

        function int pending();
            return due_responses.size();
        endfunction

        // work out the beats caused by one accepted command
        function void accept_command(cmd_t c);
            rsp_t       closing;
            rsp_t       fire;
            logic [1:0] status;
            int         hit;
            closing      = '0;
            closing.last = 1'b1;
            status       = STATUS_DONE;
            hit          = -1;
            case (c.kind)
                KIND_TICK:
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (used[i])
                        begin
                            if (expired[i])
                            begin
                                used[i]    = 1'b0;
                                expired[i] = 1'b0;
                            end
                            else
                            begin
                                rec[i].elapsed = rec[i].elapsed + ELAPSED_W'(TICK_MS);
                                if (rec[i].elapsed >= {1'b0, rec[i].period})
                                begin
                                    rec[i].elapsed     = '0;
                                    fire               = '0;
                                    fire.fired         = 1'b1;
                                    fire.fired_id      = rec[i].owner;
                                    fire.fired_custom  = rec[i].custom;
                                    fire.notify_signal = rec[i].notify[0];
                                    fire.notify_work   = rec[i].notify[1];
                                    due_responses.push_back(fire);
                                end
                            end
                        end
                    end
                end
                KIND_ADD:
                begin
                    status = STATUS_FULL;
                    for (int i = 0; i < NUM_TIMERS && hit < 0; i++)
                    begin
                        if (used[i] && rec[i].owner == c.timer_id &&
                            rec[i].custom == c.custom_id)
                            hit = i;
                    end
                    if (hit >= 0)
                    begin
                        rec[hit].period = c.period_ms;
                        status          = STATUS_UPDATED;
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_TIMERS && hit < 0; i++)
                        begin
                            if (!used[i])
                                hit = i;
                        end
                        if (hit >= 0)
                        begin
                            used[hit]           = 1'b1;
                            expired[hit]        = 1'b0;
                            rec[hit].owner      = c.timer_id;
                            rec[hit].custom     = c.custom_id;
                            rec[hit].period     = c.period_ms;
                            rec[hit].elapsed    = '0;
                            rec[hit].notify     = {c.want_work, c.want_signal};
                            status              = STATUS_ADDED;
                        end
                    end
                end
                KIND_REMOVE:
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (used[i] && rec[i].owner == c.timer_id &&
                            (c.any_custom || rec[i].custom == c.custom_id))
                            expired[i] = 1'b1;
                    end
                end
                default: ;
            endcase
            closing.status = status;
            due_responses.push_back(closing);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            logic bad;
            if (due_responses.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("unexpected response beat: %h", got);
                end
            end
            else
            begin
                want = due_responses.pop_front();
                bad  = (got.fired !== want.fired) ||
                       (got.fired_id !== want.fired_id) ||
                       (got.fired_custom !== want.fired_custom) ||
                       (got.notify_signal !== want.notify_signal) ||
                       (got.notify_work !== want.notify_work) ||
                       (got.status !== want.status) ||
                       (got.last !== want.last);
                if (bad)
                begin
                    errors++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("mismatch (expected/actual): fired %b/%b id %h/%h",
                                 want.fired, got.fired, want.fired_id, got.fired_id,
                                 " custom %h/%h sig %b/%b",
                                 want.fired_custom, got.fired_custom,
                                 want.notify_signal, got.notify_signal,
                                 " work %b/%b status %0d/%0d last %b/%b",
                                 want.notify_work, got.notify_work,
                                 want.status, got.status, want.last, got.last);
                    end
                end
            end
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    logic         calm   = 1'b0;
    int           cycles = 0;
    timer_checker chk    = new();

    periodic_timer_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random back-pressure, held off during the calm stretch
    always @(negedge clk)
    begin
        if (rst_n)
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            chk.check_response(rsp);
    end

    // call at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input cmd_t c);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        chk.accept_command(c);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (chk.pending() != 0)
            @(negedge clk);
    endtask

    task automatic send_tick();
        cmd_t c;
        c      = '0;
        c.kind = KIND_TICK;
        send_beat(c);
    endtask

    task automatic send_add(input logic [15:0] id, input logic [15:0] cust,
                            input logic [23:0] per, input logic sig, input logic work);
        cmd_t c;
        c             = '0;
        c.kind        = KIND_ADD;
        c.timer_id    = id;
        c.custom_id   = cust;
        c.period_ms   = per;
        c.want_signal = sig;
        c.want_work   = work;
        send_beat(c);
    endtask

    task automatic send_remove(input logic [15:0] id, input logic [15:0] cust,
                               input logic any);
        cmd_t c;
        c            = '0;
        c.kind       = KIND_REMOVE;
        c.timer_id   = id;
        c.custom_id  = cust;
        c.any_custom = any;
        send_beat(c);
    endtask

    // mostly well-formed traffic on a small id pool, so matches and a full table occur
    function automatic cmd_t make_random_command();
        cmd_t c;
        int   pick;
        c             = '0;
        c.period_ms   = 24'($urandom);
        c.any_custom  = 1'($urandom_range(1));
        c.want_signal = 1'($urandom_range(1));
        c.want_work   = 1'($urandom_range(1));
        c.timer_id    = 16'($urandom_range(5));
        c.custom_id   = 16'($urandom_range(3));
        pick          = $urandom_range(99);
        if (pick < 45)
        begin
            c.kind = KIND_ADD;
            if ($urandom_range(9) == 0)
                c.period_ms = 24'($urandom);
            else
                c.period_ms = 24'($urandom_range(60));
        end
        else if (pick < 75)
        begin
            c.kind = KIND_TICK;
        end
        else if (pick < 90)
        begin
            c.kind = KIND_REMOVE;
        end
        else if (pick < 95)
        begin
            c.kind      = KIND_ADD;
            c.timer_id  = 16'($urandom);
            c.custom_id = 16'($urandom);
            c.period_ms = 24'($urandom_range(40));
        end
        else
        begin
            c.kind      = 2'($urandom_range(3));
            c.timer_id  = 16'($urandom);
            c.custom_id = 16'($urandom);
            c.period_ms = 24'($urandom);
        end
        return c;
    endfunction

    initial
    begin
        cmd_t c;
        int   counted;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        send_tick();
        send_add(16'h0000, 16'h0000, 24'd0, 1'b0, 1'b0);
        send_tick();
        send_add(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b1);
        send_add(16'h0000, 16'h0000, 24'd30, 1'b1, 1'b1);
        send_add(16'h1234, 16'hABCD, 24'd25, 1'b1, 1'b0);
        send_add(16'h0077, 16'h0001, 24'd9, 1'b0, 1'b1);
        send_tick();
        send_tick();
        // lower the period below the running counter
        send_add(16'h0000, 16'h0000, 24'd5, 1'b0, 1'b0);
        send_tick();
        send_remove(16'h1234, 16'h0BAD, 1'b0);
        send_remove(16'h1234, 16'h0000, 1'b1);
        // update an expired entry, then let the tick free it
        send_add(16'h1234, 16'hABCD, 24'd10, 1'b0, 1'b0);
        send_tick();
        send_tick();
        send_remove(16'hFFFF, 16'hFFFF, 1'b0);
        send_tick();
        c           = '1;
        c.kind      = KIND_SPARE;
        send_beat(c);
        send_remove(16'h0077, 16'hFFFF, 1'b1);
        send_tick();
        wait_drained();

        // random part
        counted = 0;
        while (counted < ITEM_TARGET)
        begin
            calm = (counted >= 150 && counted < 230);
            if (counted > 0 && counted % 100 == 0)
                wait_drained();
            if ($urandom_range(99) < 3)
            begin
                // fill burst: drives the table full
                for (int k = 0; k < 18; k++)
                begin
                    send_add(16'($urandom), 16'($urandom), 24'($urandom_range(50)),
                             1'($urandom), 1'($urandom));
                    counted++;
                end
            end
            else
            begin
                c = make_random_command();
                send_beat(c);
                if (c.kind != KIND_SPARE)
                    counted++;
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (chk.errors == 0 && chk.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
